FILE: rtl/battery_fan_speed_arbiter_top_macros.svh
// Assertion macros used by the fan speed arbiter back end.
`ifndef BATTERY_FAN_SPEED_ARBITER_TOP_MACROS_SVH
`define BATTERY_FAN_SPEED_ARBITER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define BFSA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/bfsa_pkg.sv
// Types, constants and register codes of the fan speed arbiter.
package bfsa_pkg;

  localparam int unsigned KeyonSampleMs   = 300000;
  localparam int unsigned PluggedSampleMs = 600000;
  localparam int unsigned KeyoffSampleMs  = 3600000;
  localparam int          RunawayC        = 60;
  localparam int          FaultHighC      = 127;
  localparam int          FaultLowC       = -40;
  localparam int          QueueDepth      = 2;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegCoolAbove   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegHeatBelow   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegHighDelta   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegCabinDelta  = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRiseHold    = 4'd4;
  localparam logic [CfgIdxW-1:0] RegFallHold    = 4'd5;
  localparam logic [CfgIdxW-1:0] RegIntakeValid = 4'd6;
  localparam logic [CfgIdxW-1:0] RegSampleOn    = 4'd7;

  localparam logic [1:0] SpeedOff  = 2'd0;
  localparam logic [1:0] SpeedLow  = 2'd1;
  localparam logic [1:0] SpeedMed  = 2'd2;
  localparam logic [1:0] SpeedHigh = 2'd3;

  typedef enum logic [2:0] {
    ClsUnknown = 3'd0,
    ClsRunaway = 3'd1,
    ClsHot     = 3'd2,
    ClsWarm    = 3'd3,
    ClsOk      = 3'd4,
    ClsCool    = 3'd5,
    ClsCold    = 3'd6
  } cls_e;

  typedef enum logic [1:0] {
    RelUnknown = 2'd0,
    RelHotter  = 2'd1,
    RelClose   = 2'd2,
    RelColder  = 2'd3
  } rel_e;

  typedef struct packed {
    logic [7:0]  cool_above_c;
    logic [7:0]  heat_below_c;
    logic [6:0]  high_speed_delta_c;
    logic [6:0]  cabin_delta_c;
    logic [31:0] rise_hold_ms;
    logic [31:0] fall_hold_ms;
    logic [31:0] intake_valid_ms;
    logic [31:0] sample_on_ms;
  } cfg_t;

  // One classified tick as it sits in the queue.
  typedef struct packed {
    logic [31:0] now_ms;
    cls_e        cls;
    rel_e        rel;
    logic [1:0]  user_speed;
    logic [1:0]  charger_speed;
    logic [1:0]  balance_speed;
    logic        thermal_allowed;
    logic        key_on;
    logic        charger_plugged;
  } item_t;

endpackage

FILE: rtl/bfsa_if.sv
// Channel interfaces: tick input, result output and register writes.
interface bfsa_in_if;
  logic              valid;
  logic              ready;
  logic [31:0]       now_ms;
  logic signed [7:0] pack_temp;
  logic signed [7:0] intake_temp;
  logic [1:0]        user_speed;
  logic [1:0]        charger_speed;
  logic [1:0]        balance_speed;
  logic              thermal_allowed;
  logic              heater_present;
  logic              key_on;
  logic              charger_plugged;

  modport source (output valid, now_ms, pack_temp, intake_temp, user_speed, charger_speed,
                  balance_speed, thermal_allowed, heater_present, key_on, charger_plugged,
                  input ready);
  modport sink (input valid, now_ms, pack_temp, intake_temp, user_speed, charger_speed,
                balance_speed, thermal_allowed, heater_present, key_on, charger_plugged,
                output ready);
endinterface

interface bfsa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] fan_speed;
  logic [1:0] goal_speed;
  logic [1:0] battery_request;
  logic       intake_valid;

  modport source (output valid, fan_speed, goal_speed, battery_request, intake_valid,
                  input ready);
  modport sink (input valid, fan_speed, goal_speed, battery_request, intake_valid,
                output ready);
endinterface

interface bfsa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfsa_pkg::CfgIdxW-1:0]  index;
  logic [bfsa_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/bfsa_front.sv
// Front end: accept a tick, classify the pack and its relation to intake air.
module bfsa_front #(
  parameter int RUNAWAY_C    = bfsa_pkg::RunawayC,
  parameter int FAULT_HIGH_C = bfsa_pkg::FaultHighC,
  parameter int FAULT_LOW_C  = bfsa_pkg::FaultLowC
) (
  bfsa_in_if.sink          in_i,
  input  bfsa_pkg::cfg_t   cfg_i,
  input  logic             q_ready_i,
  output logic             push_o,
  output bfsa_pkg::item_t  item_o
);

  localparam logic signed [9:0] RunawayT   = 10'(RUNAWAY_C);
  localparam logic signed [9:0] FaultHighT = 10'(FAULT_HIGH_C);
  localparam logic signed [9:0] FaultLowT  = 10'(FAULT_LOW_C);

  logic signed [9:0] pack_w, intake_w, cool_w, heat_w, delta_w, cabin_w;
  logic signed [9:0] hot_thr, cool_thr, hotter_thr, close_thr;
  bfsa_pkg::cls_e    cls;
  bfsa_pkg::rel_e    rel;

  // Widen everything to ten signed bits so threshold sums cannot wrap.
  assign pack_w   = $signed({{2{in_i.pack_temp[7]}}, in_i.pack_temp});
  assign intake_w = $signed({{2{in_i.intake_temp[7]}}, in_i.intake_temp});
  assign cool_w   = $signed({{2{cfg_i.cool_above_c[7]}}, cfg_i.cool_above_c});
  assign heat_w   = $signed({{2{cfg_i.heat_below_c[7]}}, cfg_i.heat_below_c});
  assign delta_w  = $signed({3'b000, cfg_i.high_speed_delta_c});
  assign cabin_w  = $signed({3'b000, cfg_i.cabin_delta_c});

  assign hot_thr    = cool_w + delta_w;
  assign cool_thr   = heat_w - delta_w;
  assign hotter_thr = intake_w + cabin_w;
  assign close_thr  = intake_w - cabin_w;

  always_comb begin
    priority if (pack_w > RunawayT) begin
      cls = bfsa_pkg::ClsRunaway;
    end else if (pack_w > hot_thr) begin
      cls = bfsa_pkg::ClsHot;
    end else if (pack_w > cool_w) begin
      cls = bfsa_pkg::ClsWarm;
    end else if (pack_w > heat_w) begin
      cls = bfsa_pkg::ClsOk;
    end else if (pack_w > cool_thr) begin
      cls = in_i.heater_present ? bfsa_pkg::ClsOk : bfsa_pkg::ClsCool;
    end else if (pack_w > FaultLowT) begin
      cls = in_i.heater_present ? bfsa_pkg::ClsOk : bfsa_pkg::ClsCold;
    end else begin
      cls = bfsa_pkg::ClsUnknown;
    end
  end

  always_comb begin
    priority if (pack_w == FaultHighT) begin
      rel = bfsa_pkg::RelUnknown;
    end else if (pack_w > hotter_thr) begin
      rel = bfsa_pkg::RelHotter;
    end else if (pack_w > close_thr) begin
      rel = bfsa_pkg::RelClose;
    end else if (pack_w > FaultLowT) begin
      rel = bfsa_pkg::RelColder;
    end else begin
      rel = bfsa_pkg::RelUnknown;
    end
  end

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

  always_comb begin
    item_o.now_ms          = in_i.now_ms;
    item_o.cls             = cls;
    item_o.rel             = rel;
    item_o.user_speed      = in_i.user_speed;
    item_o.charger_speed   = in_i.charger_speed;
    item_o.balance_speed   = in_i.balance_speed;
    item_o.thermal_allowed = in_i.thermal_allowed;
    item_o.key_on          = in_i.key_on;
    item_o.charger_plugged = in_i.charger_plugged;
  end

endmodule

FILE: rtl/bfsa_queue.sv
// Short FIFO of classified ticks between front and back.
module bfsa_queue #(
  parameter int DEPTH = bfsa_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bfsa_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            ready_o,
  output logic            valid_o,
  output bfsa_pkg::item_t item_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  bfsa_pkg::item_t slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o = (count_q != FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/bfsa_back.sv
// Back end: intake tracking, sampler, goal arbitration, hold timing and result register.
`include "battery_fan_speed_arbiter_top_macros.svh"

module bfsa_back #(
  parameter int unsigned KEYON_SAMPLE_MS   = bfsa_pkg::KeyonSampleMs,
  parameter int unsigned PLUGGED_SAMPLE_MS = bfsa_pkg::PluggedSampleMs,
  parameter int unsigned KEYOFF_SAMPLE_MS  = bfsa_pkg::KeyoffSampleMs
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfsa_pkg::cfg_t  cfg_i,
  input  logic            head_valid_i,
  input  bfsa_pkg::item_t head_i,
  output logic            pop_o,
  bfsa_out_if.source      out_o
);

  localparam logic [31:0] KeyonIval   = 32'(KEYON_SAMPLE_MS);
  localparam logic [31:0] PluggedIval = 32'(PLUGGED_SAMPLE_MS);
  localparam logic [31:0] KeyoffIval  = 32'(KEYOFF_SAMPLE_MS);
  localparam logic [31:0] SampleReset = 32'hFFFF_FFFF - KeyoffIval;

  logic [1:0]  speed_now_q, speed_now_d, speed_seen_q;
  logic [1:0]  acc_goal_q, acc_goal_d;
  logic [31:0] fan_off_q, fan_off_d;
  logic [31:0] change_q, change_d;
  logic [31:0] sample_start_q, sample_start_d;

  logic        out_valid_q;
  logic [1:0]  out_fan_q, out_goal_q, out_breq_q;
  logic        out_intake_q;

  logic        pop;
  logic        intake_ok;
  logic [31:0] now, elapsed, interval, hold;
  logic        samp_req, samp_restart, needs_sample;
  logic [1:0]  breq, goal;

  assign now = head_i.now_ms;
  assign pop = head_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = pop;

  // Latch the time the fan went off once the change is first seen.
  assign fan_off_d = ((speed_now_q != speed_seen_q) && (speed_now_q == bfsa_pkg::SpeedOff))
                   ? now : fan_off_q;
  assign intake_ok = (speed_now_q != bfsa_pkg::SpeedOff) ||
                     ((now - fan_off_d) < cfg_i.intake_valid_ms);

  assign interval = head_i.key_on ? KeyonIval :
                    (head_i.charger_plugged ? PluggedIval : KeyoffIval);
  assign elapsed      = now - sample_start_q;
  assign samp_restart = elapsed > interval;
  assign samp_req     = (elapsed < cfg_i.sample_on_ms) || samp_restart;

  assign needs_sample = !intake_ok &&
                        ((head_i.cls == bfsa_pkg::ClsHot)  || (head_i.cls == bfsa_pkg::ClsWarm) ||
                         (head_i.cls == bfsa_pkg::ClsCool) || (head_i.cls == bfsa_pkg::ClsCold));

  always_comb begin
    breq = bfsa_pkg::SpeedOff;
    if (intake_ok) begin
      unique case (head_i.cls)
        bfsa_pkg::ClsHot:  breq = (head_i.rel == bfsa_pkg::RelHotter) ? bfsa_pkg::SpeedHigh
                                                                      : bfsa_pkg::SpeedOff;
        bfsa_pkg::ClsWarm: breq = (head_i.rel == bfsa_pkg::RelHotter) ? bfsa_pkg::SpeedLow
                                                                      : bfsa_pkg::SpeedOff;
        bfsa_pkg::ClsCool: breq = (head_i.rel == bfsa_pkg::RelColder) ? bfsa_pkg::SpeedLow
                                                                      : bfsa_pkg::SpeedOff;
        bfsa_pkg::ClsCold: breq = (head_i.rel == bfsa_pkg::RelColder) ? bfsa_pkg::SpeedHigh
                                                                      : bfsa_pkg::SpeedOff;
        default:           breq = bfsa_pkg::SpeedOff;
      endcase
    end else if (needs_sample) begin
      breq = samp_req ? bfsa_pkg::SpeedLow : bfsa_pkg::SpeedOff;
    end
  end

  always_comb begin
    goal = breq;
    if (head_i.user_speed > goal) goal = head_i.user_speed;
    if (head_i.charger_speed > goal) goal = head_i.charger_speed;
    if (head_i.balance_speed > goal) goal = head_i.balance_speed;
  end

  assign sample_start_d = (needs_sample && samp_restart) ? now : sample_start_q;
  assign hold = (goal > acc_goal_q) ? cfg_i.rise_hold_ms : cfg_i.fall_hold_ms;

  always_comb begin
    speed_now_d = speed_now_q;
    acc_goal_d  = acc_goal_q;
    change_d    = change_q;
    if (!head_i.thermal_allowed) begin
      speed_now_d = bfsa_pkg::SpeedOff;
    end else if (speed_now_q != goal) begin
      if (goal == acc_goal_q) begin
        speed_now_d = goal;
      end else if ((now - change_q) >= hold) begin
        speed_now_d = goal;
        acc_goal_d  = goal;
        change_d    = now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_now_q    <= bfsa_pkg::SpeedOff;
      speed_seen_q   <= bfsa_pkg::SpeedOff;
      acc_goal_q     <= bfsa_pkg::SpeedOff;
      fan_off_q      <= '0;
      change_q       <= '0;
      sample_start_q <= SampleReset;
      out_valid_q    <= 1'b0;
    end else begin
      if (pop) begin
        speed_now_q    <= speed_now_d;
        speed_seen_q   <= speed_now_q;
        acc_goal_q     <= acc_goal_d;
        fan_off_q      <= fan_off_d;
        change_q       <= change_d;
        sample_start_q <= sample_start_d;
        out_valid_q    <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_fan_q    <= speed_now_d;
      out_goal_q   <= goal;
      out_breq_q   <= breq;
      out_intake_q <= intake_ok;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.fan_speed       = out_fan_q;
  assign out_o.goal_speed      = out_goal_q;
  assign out_o.battery_request = out_breq_q;
  assign out_o.intake_valid    = out_intake_q;

  `BFSA_ASSERT(a_off_when_denied, pop && !head_i.thermal_allowed |=> out_o.fan_speed == bfsa_pkg::SpeedOff, "fan not forced off without energy")
  `BFSA_ASSERT(a_speed_is_accepted, (speed_now_q != $past(speed_now_q)) && (speed_now_q != bfsa_pkg::SpeedOff) |-> speed_now_q == acc_goal_q, "speed moved to a goal that was not accepted")
  `BFSA_ASSERT_NEVER(a_breq_never_med, out_valid_q && (out_breq_q == bfsa_pkg::SpeedMed), "battery request coded medium")

endmodule

FILE: rtl/battery_fan_speed_arbiter_top.sv
// Top level of the battery fan speed arbiter: config registers, front, queue and back.
//
//  channel | dir | beat carries                                        | accepted when
//  --------+-----+-----------------------------------------------------+--------------
//  in_i    | in  | now_ms, temps, three requests, four status flags     | valid && ready
//  out_o   | out | fan_speed, goal_speed, battery_request, intake_valid | valid && ready
//  cfg_i   | in  | register index, write data                          | valid && ready
//
//  A tick is classified combinationally and written into the queue at its accepting
//  edge; the back pops it from the queue into the result register once that register is
//  free, and the result is then offered on out_o until it is taken.
//  A tick can be taken every cycle while out_o accepts results; the back's per-tick state update sets that rate.
//  Reset loads the register defaults and timing state. Config writes are always taken.
//  A stalled result holds in the output register while the queue fills; then in_i.ready drops.
module battery_fan_speed_arbiter_top #(
  parameter int unsigned KEYON_SAMPLE_MS   = bfsa_pkg::KeyonSampleMs,
  parameter int unsigned PLUGGED_SAMPLE_MS = bfsa_pkg::PluggedSampleMs,
  parameter int unsigned KEYOFF_SAMPLE_MS  = bfsa_pkg::KeyoffSampleMs,
  parameter int          RUNAWAY_C         = bfsa_pkg::RunawayC,
  parameter int          FAULT_HIGH_C      = bfsa_pkg::FaultHighC,
  parameter int          FAULT_LOW_C       = bfsa_pkg::FaultLowC,
  parameter int          QUEUE_DEPTH       = bfsa_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfsa_in_if.sink     in_i,
  bfsa_out_if.source  out_o,
  bfsa_cfg_if.sink    cfg_i
);

  bfsa_pkg::cfg_t  cfg_q;
  bfsa_pkg::item_t front_item, head_item;
  logic            push, pop, q_ready, head_valid;

  // Registers take a write every cycle; the user must write them only while idle, the block itself does not enforce it.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cool_above_c       <= 8'd35;
      cfg_q.heat_below_c       <= 8'd10;
      cfg_q.high_speed_delta_c <= 7'd5;
      cfg_q.cabin_delta_c      <= 7'd2;
      cfg_q.rise_hold_ms       <= 32'd10000;
      cfg_q.fall_hold_ms       <= 32'd30000;
      cfg_q.intake_valid_ms    <= 32'd60000;
      cfg_q.sample_on_ms       <= 32'd30000;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bfsa_pkg::RegCoolAbove:   cfg_q.cool_above_c       <= cfg_i.data[7:0];
        bfsa_pkg::RegHeatBelow:   cfg_q.heat_below_c       <= cfg_i.data[7:0];
        bfsa_pkg::RegHighDelta:   cfg_q.high_speed_delta_c <= cfg_i.data[6:0];
        bfsa_pkg::RegCabinDelta:  cfg_q.cabin_delta_c      <= cfg_i.data[6:0];
        bfsa_pkg::RegRiseHold:    cfg_q.rise_hold_ms       <= cfg_i.data[31:0];
        bfsa_pkg::RegFallHold:    cfg_q.fall_hold_ms       <= cfg_i.data[31:0];
        bfsa_pkg::RegIntakeValid: cfg_q.intake_valid_ms    <= cfg_i.data[31:0];
        bfsa_pkg::RegSampleOn:    cfg_q.sample_on_ms       <= cfg_i.data[31:0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // Classify each tick as it arrives.
  bfsa_front #(
    .RUNAWAY_C    (RUNAWAY_C),
    .FAULT_HIGH_C (FAULT_HIGH_C),
    .FAULT_LOW_C  (FAULT_LOW_C)
  ) u_front (
    .in_i      (in_i),
    .cfg_i     (cfg_q),
    .q_ready_i (q_ready),
    .push_o    (push),
    .item_o    (front_item)
  );

  // Decouple intake from the stateful back end.
  bfsa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .ready_o (q_ready),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  // Advance the fan state one tick per popped beat.
  bfsa_back #(
    .KEYON_SAMPLE_MS   (KEYON_SAMPLE_MS),
    .PLUGGED_SAMPLE_MS (PLUGGED_SAMPLE_MS),
    .KEYOFF_SAMPLE_MS  (KEYOFF_SAMPLE_MS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
